[rtl/aes_pkg.sv]
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, register addresses and round helpers for the aes register device
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam logic [5:0] ADDR_CTRL   = 6'h08;
	localparam logic [5:0] ADDR_STATUS = 6'h09;
	localparam logic [5:0] ADDR_MODE   = 6'h0a;
	localparam logic [5:0] ADDR_KEY    = 6'h10;
	localparam logic [5:0] ADDR_KEY_HI = 6'h14;
	localparam logic [5:0] ADDR_BLOCK  = 6'h20;
	localparam logic [5:0] ADDR_RESULT = 6'h30;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// controller state, one-hot
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXPAND = 4'b0010,
		ST_CIPHER = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic       exp_start;  // load key into expansion window
		logic       exp_step;   // produce next 4 words of the schedule
		logic       blk_start;  // load block and add first round key
		logic       blk_round;  // one middle round
		logic       blk_last;   // final round, write result
		logic [3:0] cnt;        // round index in use
	} cmd_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// state byte i = column i/4, row i%4, byte 0 at msb
	function automatic logic [7:0] sb(input logic [127:0] s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic mix);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(4*c + r) -: 8] = sbox(sb(s, 4*((c + r) % 4) + r));
			end
		end
		if (mix) begin
			for (int c = 0; c < 4; c++) begin
				a0 = sb(t, 4*c); a1 = sb(t, 4*c + 1); a2 = sb(t, 4*c + 2); a3 = sb(t, 4*c + 3);
				t[127 - 32*c -: 32] = {
					xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
					a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
					a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
					xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(4*((c + r) % 4) + r) -: 8] = inv_sbox(sb(s, 4*c + r));
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a [4];
		logic [7:0]   x2 [4];
		logic [7:0]   x4 [4];
		logic [7:0]   x8 [4];
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r]  = sb(s, 4*c + r);
				x2[r] = xtime(a[r]);
				x4[r] = xtime(x2[r]);
				x8[r] = xtime(x4[r]);
			end
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(4*c + r) -: 8] =
					(x8[r] ^ x4[r] ^ x2[r]) ^
					(x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
					(x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
					(x8[(r+3)%4] ^ a[(r+3)%4]);
			end
		end
		return t;
	endfunction

endpackage

[rtl/aes_ctrl.sv]
// ----------------------------------------------------------------------------
// aes_ctrl
// sequencer for key expansion and block rounds
// ----------------------------------------------------------------------------
module aes_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_go,
	input  logic               req_expand,
	input  logic               req_cipher,
	input  logic               long_key,
	input  logic               encrypt,
	input  logic               out_stall,
	output logic               busy,
	output logic               out_valid,
	output aes_pkg::cmd_t      cmd
);

	// last round key entry; a 128-bit schedule fills the entries past round 10 with zero
	localparam logic [3:0] LAST_RK = 4'd14;

	aes_pkg::state_t state_q;
	logic [3:0]      cnt_q;
	logic [3:0]      nr;

	// 10 or 14 rounds
	assign nr = long_key ? 4'd14 : 4'd10;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.cnt = cnt_q;
		case (state_q)
			aes_pkg::ST_IDLE: begin
				cmd.exp_start = req_go && req_expand;
				cmd.blk_start = req_go && !req_expand && req_cipher;
				cmd.cnt       = encrypt ? 4'd0 : nr;
			end
			aes_pkg::ST_EXPAND: cmd.exp_step = 1'b1;
			aes_pkg::ST_CIPHER: begin
				if ((encrypt && cnt_q == nr) || (!encrypt && cnt_q == 4'd0)) begin
					cmd.blk_last = 1'b1;
				end else begin
					cmd.blk_round = 1'b1;
				end
			end
			aes_pkg::ST_DONE: ;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				aes_pkg::ST_IDLE: begin
					if (req_go) begin
						if (cmd.exp_start) begin
							state_q <= aes_pkg::ST_EXPAND;
							cnt_q   <= long_key ? 4'd2 : 4'd1;
						end else if (cmd.blk_start) begin
							state_q <= aes_pkg::ST_CIPHER;
							cnt_q   <= encrypt ? 4'd1 : nr - 4'd1;
						end else begin
							state_q <= aes_pkg::ST_DONE;
						end
					end
				end
				aes_pkg::ST_EXPAND: begin
					if (cnt_q == LAST_RK) begin
						state_q <= aes_pkg::ST_DONE;
					end
					cnt_q <= cnt_q + 4'd1;
				end
				aes_pkg::ST_CIPHER: begin
					if (cmd.blk_last) begin
						state_q <= aes_pkg::ST_DONE;
					end
					cnt_q <= encrypt ? cnt_q + 4'd1 : cnt_q - 4'd1;
				end
				aes_pkg::ST_DONE: begin
					if (!out_stall) begin
						state_q <= aes_pkg::ST_IDLE;
					end
				end
				default: state_q <= aes_pkg::ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != aes_pkg::ST_IDLE);
	assign out_valid = (state_q == aes_pkg::ST_DONE);

endmodule

[rtl/aes_dp.sv]
// ----------------------------------------------------------------------------
// aes_dp
// register file, key schedule, round key memory and round datapath
// ----------------------------------------------------------------------------
module aes_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_go,
	input  logic          action,
	input  logic [5:0]    address,
	input  logic [31:0]   write_data,
	input  logic          busy,
	input  aes_pkg::cmd_t cmd,
	output logic          long_key,
	output logic          encrypt,
	output logic [31:0]   read_data
);

	logic [31:0]  key_q [8];
	logic [31:0]  blk_q [4];
	logic [127:0] res_q;
	logic [1:0]   mode_q;
	logic         valid_q;
	logic [31:0]  rd_q;
	logic [127:0] rk_mem [15];
	logic [255:0] win_q;
	logic [7:0]   rcon_q;
	logic         half_q;
	logic [127:0] st_q;
	logic [127:0] rk;
	logic [127:0] nxt_blk;
	logic [31:0]  w0, w1, w2, w3, tw;
	logic [127:0] fwd, inv_ss;

	assign long_key = mode_q[1];
	assign encrypt  = mode_q[0];
	assign rk       = rk_mem[cmd.cnt];

	// next schedule block; window holds the previous nk words, newest at low end
	always_comb begin
		if (long_key) begin
			tw = half_q ? aes_pkg::sub_word(win_q[31:0])
			            : aes_pkg::sub_word({win_q[23:0], win_q[31:24]}) ^ {rcon_q, 24'h0};
			w0 = win_q[255:224] ^ tw;
			w1 = win_q[223:192] ^ w0;
			w2 = win_q[191:160] ^ w1;
			w3 = win_q[159:128] ^ w2;
		end else begin
			tw = aes_pkg::sub_word({win_q[23:0], win_q[31:24]}) ^ {rcon_q, 24'h0};
			w0 = win_q[127:96] ^ tw;
			w1 = win_q[95:64] ^ w0;
			w2 = win_q[63:32] ^ w1;
			w3 = win_q[31:0] ^ w2;
		end
		nxt_blk = {w0, w1, w2, w3};
	end

	assign fwd    = aes_pkg::fwd_round(st_q, cmd.blk_round) ^ rk;
	assign inv_ss = aes_pkg::inv_shift_sub(st_q) ^ rk;

	// key schedule and round key memory; cnt names the block being written
	always_ff @(posedge clk) begin
		if (cmd.exp_start) begin
			// a 128-bit key sits in the low half of the window
			win_q  <= long_key ? {key_q[0], key_q[1], key_q[2], key_q[3],
			                      key_q[4], key_q[5], key_q[6], key_q[7]}
			                   : {128'd0, key_q[0], key_q[1], key_q[2], key_q[3]};
			rcon_q <= 8'h01;
			half_q <= 1'b0;
			rk_mem[0] <= {key_q[0], key_q[1], key_q[2], key_q[3]};
			if (long_key) begin
				rk_mem[1] <= {key_q[4], key_q[5], key_q[6], key_q[7]};
			end
		end else if (cmd.exp_step) begin
			if (cmd.cnt <= (long_key ? 4'd14 : 4'd10)) begin
				rk_mem[cmd.cnt] <= nxt_blk;
				if (long_key) begin
					win_q  <= {win_q[127:0], nxt_blk};
					half_q <= !half_q;
					if (!half_q) begin
						rcon_q <= aes_pkg::xtime(rcon_q);
					end
				end else begin
					win_q[127:0] <= nxt_blk;
					rcon_q       <= aes_pkg::xtime(rcon_q);
				end
			end else begin
				rk_mem[cmd.cnt] <= '0;
			end
		end
	end

	// round datapath
	always_ff @(posedge clk) begin
		if (cmd.blk_start) begin
			st_q <= {blk_q[0], blk_q[1], blk_q[2], blk_q[3]} ^ rk;
		end else if (cmd.blk_round) begin
			st_q <= encrypt ? fwd : aes_pkg::inv_mix(inv_ss);
		end else if (cmd.blk_last) begin
			st_q <= encrypt ? fwd : inv_ss;
		end
	end

	// software visible registers and read port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) key_q[i] <= '0;
			for (int i = 0; i < 4; i++) blk_q[i] <= '0;
			res_q   <= '0;
			mode_q  <= '0;
			valid_q <= 1'b0;
			rd_q    <= '0;
		end else begin
			if (cmd.blk_last) begin
				res_q   <= encrypt ? fwd : inv_ss;
				valid_q <= 1'b1;
			end
			if (cmd.exp_start) begin
				valid_q <= 1'b0;
			end
			if (req_go && !busy) begin
				rd_q <= '0;
				if (action == aes_pkg::ACT_WRITE) begin
					if (address == aes_pkg::ADDR_MODE) begin
						mode_q <= write_data[1:0];
					end else if (address >= aes_pkg::ADDR_KEY &&
					             address < aes_pkg::ADDR_KEY_HI + 6'd4) begin
						key_q[address[2:0]] <= write_data;
					end else if (address >= aes_pkg::ADDR_BLOCK &&
					             address < aes_pkg::ADDR_BLOCK + 6'd4) begin
						blk_q[address[1:0]] <= write_data;
					end
				end else begin
					if (address == aes_pkg::ADDR_STATUS) begin
						rd_q <= {30'd0, valid_q, 1'b1};
					end else if (address >= aes_pkg::ADDR_RESULT &&
					             address < aes_pkg::ADDR_RESULT + 6'd4) begin
						rd_q <= res_q[127 - 32*address[1:0] -: 32];
					end
				end
			end
		end
	end

	assign read_data = rd_q;

endmodule

[rtl/aes_core_register_device.sv]
// ----------------------------------------------------------------------------
// aes_core_register_device
// aes-128/256 cipher core behind a 32-bit register interface
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_stall) carries one register access per request:
//   action, address, write_data. out channel (out_valid/out_stall) returns
//   read_data for every request, zero for writes and unmapped reads.
//   one request is handled at a time; in_stall is high while busy.
//   plain accesses answer in the cycle after acceptance.
//   key expansion command: one schedule block per cycle through an s-box
//   row; a 128-bit expansion ends by clearing the four unused round keys.
//   block command: one round per cycle over the round key memory read port.
//   the response waits in its register while out_stall is high; no new
//   request is taken until it is delivered, and the next one is accepted
//   in the cycle after delivery at the earliest.
//   reset clears key, block, result, mode and status; round keys hold
//   nothing until a key expansion has run.
// ----------------------------------------------------------------------------
module aes_core_register_device (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [5:0]  address,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data
);

	aes_pkg::cmd_t cmd;
	logic          busy, long_key, encrypt, req_go, is_ctrl;

	assign in_stall = busy;
	assign req_go   = in_valid && !busy;
	assign is_ctrl  = (action == aes_pkg::ACT_WRITE) && (address == aes_pkg::ADDR_CTRL);

	aes_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_go     (req_go),
		.req_expand (is_ctrl && write_data[0]),
		.req_cipher (is_ctrl && write_data[1]),
		.long_key   (long_key),
		.encrypt    (encrypt),
		.out_stall  (out_stall),
		.busy       (busy),
		.out_valid  (out_valid),
		.cmd        (cmd)
	);

	aes_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_go     (req_go),
		.action     (action),
		.address    (address),
		.write_data (write_data),
		.busy       (busy),
		.cmd        (cmd),
		.long_key   (long_key),
		.encrypt    (encrypt),
		.read_data  (read_data)
	);

	// a response is only pending while the core is busy
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy) else $error("response without busy");

	// an accepted request always leaves the idle state
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> busy) else $error("request dropped");

	// commands are mutually exclusive
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.exp_start, cmd.exp_step, cmd.blk_start, cmd.blk_round, cmd.blk_last}))
		else $error("overlapping commands");

endmodule

[sim/aes_reg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_reg_checker
// watches both channels of the aes register device, predicts every read word
// from its own cipher model and compares each response in order
// ----------------------------------------------------------------------------
module aes_reg_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        action,
	input  logic [5:0]  address,
	input  logic [31:0] write_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] read_data,
	output int          fail_count,
	output int          pending
);

	logic [31:0]  key_reg [8];
	logic [127:0] block_reg;
	logic [127:0] result_reg;
	logic [127:0] sched [15];
	logic [1:0]   mode_reg;
	logic         done_flag;
	logic [31:0]  read_q [$];

	function automatic logic [7:0] fwd_sub(input logic [7:0] a);
		logic [7:0] p, q, r;
		// s-box from gf inverse and affine map
		p = 8'h01;
		if (a != 0) begin
			for (int i = 1; i < 256; i++) begin
				q = gf_mul(a, i[7:0]);
				if (q == 8'h01) p = i[7:0];
			end
		end else p = 8'h00;
		r = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]}
			^ {p[3:0], p[7:4]} ^ 8'h63;
		return r;
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return r;
	endfunction

	logic [7:0] fwd_tab [256];
	logic [7:0] inv_tab [256];
	initial begin
		for (int i = 0; i < 256; i++) begin
			fwd_tab[i] = fwd_sub(i[7:0]);
			inv_tab[fwd_tab[i]] = i[7:0];
		end
	end

	function automatic logic [31:0] word_sub(input logic [31:0] w);
		return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
	endfunction

	// key schedule into the round key store, unused entries zeroed
	task automatic expand_schedule();
		logic [31:0] w [60];
		logic [31:0] t;
		logic [7:0]  rc;
		int nk, total;
		nk = mode_reg[1] ? 8 : 4;
		total = 4 * (nk + 7);
		rc = 8'h01;
		for (int i = 0; i < nk; i++) w[i] = key_reg[i];
		for (int i = nk; i < total; i++) begin
			t = w[i-1];
			if (i % nk == 0) begin
				t = word_sub({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_mul(rc, 8'h02);
			end else if (nk == 8 && i % 8 == 4) t = word_sub(t);
			w[i] = w[i-nk] ^ t;
		end
		for (int r = 0; r < 15; r++) sched[r] = '0;
		for (int i = 0; i < total; i++) sched[i/4][127 - 32*(i%4) -: 32] = w[i];
	endtask

	function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	function automatic logic [127:0] rows_shift(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				if (inv) t[127 - 8*(4*((c+r)%4)+r) -: 8] = byte_at(s, 4*c+r);
				else t[127 - 8*(4*c+r) -: 8] = byte_at(s, 4*((c+r)%4)+r);
		return t;
	endfunction

	function automatic logic [127:0] bytes_sub(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		for (int i = 0; i < 16; i++)
			t[127 - 8*i -: 8] = inv ? inv_tab[byte_at(s, i)] : fwd_tab[byte_at(s, i)];
		return t;
	endfunction

	function automatic logic [127:0] cols_mix(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		logic [7:0] m [4];
		logic [7:0] a [4];
		if (inv) begin
			m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
		end else begin
			m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) a[r] = byte_at(s, 4*c+r);
			for (int r = 0; r < 4; r++)
				t[127 - 8*(4*c+r) -: 8] = gf_mul(a[r], m[0]) ^ gf_mul(a[(r+1)%4], m[1])
					^ gf_mul(a[(r+2)%4], m[2]) ^ gf_mul(a[(r+3)%4], m[3]);
		end
		return t;
	endfunction

	function automatic logic [127:0] cipher_block();
		logic [127:0] s;
		int nr;
		nr = mode_reg[1] ? 14 : 10;
		s = block_reg;
		if (mode_reg[0]) begin
			s ^= sched[0];
			for (int r = 1; r < nr; r++)
				s = cols_mix(rows_shift(bytes_sub(s, 0), 0), 0) ^ sched[r];
			s = rows_shift(bytes_sub(s, 0), 0) ^ sched[nr];
		end else begin
			s ^= sched[nr];
			for (int r = nr - 1; r >= 1; r--)
				s = cols_mix(bytes_sub(rows_shift(s, 1), 1) ^ sched[r], 1);
			s = bytes_sub(rows_shift(s, 1), 1) ^ sched[0];
		end
		return s;
	endfunction

	// apply one accepted request to the model and queue its read word
	task automatic apply_request(input logic act, input logic [5:0] a, input logic [31:0] d);
		logic [31:0] rd;
		rd = '0;
		if (act == aes_pkg::ACT_WRITE) begin
			if (a == aes_pkg::ADDR_CTRL) begin
				if (d[0]) begin
					expand_schedule();
					done_flag = 1'b0;
				end else if (d[1]) begin
					result_reg = cipher_block();
					done_flag = 1'b1;
				end
			end else if (a == aes_pkg::ADDR_MODE) mode_reg = d[1:0];
			else if (a >= aes_pkg::ADDR_KEY && a < aes_pkg::ADDR_KEY_HI + 4)
				key_reg[a - aes_pkg::ADDR_KEY] = d;
			else if (a >= aes_pkg::ADDR_BLOCK && a < aes_pkg::ADDR_BLOCK + 4)
				block_reg[127 - 32*(a - aes_pkg::ADDR_BLOCK) -: 32] = d;
		end else begin
			if (a == aes_pkg::ADDR_STATUS) rd = {30'd0, done_flag, 1'b1};
			else if (a >= aes_pkg::ADDR_RESULT && a < aes_pkg::ADDR_RESULT + 4)
				rd = result_reg[127 - 32*(a - aes_pkg::ADDR_RESULT) -: 32];
		end
		read_q.push_back(rd);
	endtask

	initial begin
		for (int i = 0; i < 8; i++) key_reg[i] = '0;
		for (int i = 0; i < 15; i++) sched[i] = '0;
		block_reg = '0;
		result_reg = '0;
		mode_reg = '0;
		done_flag = 1'b0;
		fail_count = 0;
		pending = 0;
	end

	// request side then response side, both on the same clock edge
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (in_valid && !in_stall) apply_request(action, address, write_data);
			if (out_valid && !out_stall) begin
				if (read_q.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %h",
						$time, read_data);
					fail_count++;
				end else begin
					want = read_q.pop_front();
					if (read_data !== want) begin
						$display("%0t: read_data mismatch, expected %h, actual %h",
							$time, want, read_data);
						fail_count++;
					end
				end
			end
		end
		pending = read_q.size();
	end

endmodule

[sim/aes_core_register_device_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_core_register_device_tb
// drives register access sequences (key load, mode, expand, block, result
// reads) with random gaps and response stalls; the checker judges each word
// ----------------------------------------------------------------------------
module aes_core_register_device_tb;

	localparam int IDLE_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [5:0]  address;
	logic [31:0] write_data;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] read_data;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	int          out_wait;
	logic        expanded;

	aes_core_register_device dut (.*);

	aes_reg_checker checker_i (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// receiver draws a wait for every response before taking it
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			out_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		end else if (out_valid && out_wait > 0) begin
			out_wait = out_wait - 1;
		end
		out_stall <= (out_wait > 0);
	end

	// watchdog on cycles with no accepted request or response
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// one request, with a random gap before it
	task automatic send_request(input logic act, input logic [5:0] a, input logic [31:0] d);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		address    <= a;
		write_data <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(input logic [5:0] a, input logic [31:0] d);
		send_request(aes_pkg::ACT_WRITE, a, d);
	endtask

	task automatic read_reg(input logic [5:0] a);
		send_request(aes_pkg::ACT_READ, a, $urandom());
	endtask

	// full cipher pass: key, mode, expand, block, process, read back
	task automatic cipher_pass(input logic [1:0] mode, input logic [31:0] fill);
		for (int i = 0; i < (mode[1] ? 8 : 4); i++)
			write_reg(6'(aes_pkg::ADDR_KEY + i), fill == 0 ? $urandom() : fill);
		write_reg(aes_pkg::ADDR_MODE,
			{$urandom_range(0, 1) ? $urandom() : 32'd0} & ~32'd3 | mode);
		write_reg(aes_pkg::ADDR_CTRL, 32'd1 | ($urandom_range(0, 1) << 1));
		expanded = 1'b1;
		read_reg(aes_pkg::ADDR_STATUS);
		for (int i = 0; i < 4; i++)
			write_reg(6'(aes_pkg::ADDR_BLOCK + i), fill == 0 ? $urandom() : ~fill);
		write_reg(aes_pkg::ADDR_CTRL, 32'd2 | ($urandom() & ~32'd3));
		read_reg(aes_pkg::ADDR_STATUS);
		for (int i = 0; i < 4; i++) read_reg(6'(aes_pkg::ADDR_RESULT + i));
	endtask

	initial begin
		int n;
		logic [1:0] m;
		in_valid   <= 1'b0;
		action     <= aes_pkg::ACT_WRITE;
		address    <= '0;
		write_data <= '0;
		out_stall  <= 1'b0;
		out_wait = 0;
		idle_cycles = 0;
		expanded = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset reads, all modes, extreme words
		read_reg(aes_pkg::ADDR_STATUS);
		read_reg(aes_pkg::ADDR_RESULT);
		read_reg(6'h3f);
		write_reg(aes_pkg::ADDR_STATUS, 32'hffff_ffff);
		cipher_pass(2'b01, 32'd0);
		cipher_pass(2'b00, 32'hffff_ffff);
		cipher_pass(2'b11, 32'd0);
		cipher_pass(2'b10, 32'd0);
		// length changed since expansion
		write_reg(aes_pkg::ADDR_MODE, 32'd1);
		write_reg(aes_pkg::ADDR_CTRL, 32'd2);
		read_reg(6'(aes_pkg::ADDR_RESULT + 3));

		// random: mostly full passes, some noise
		n = 0;
		while (n < 1450) begin
			if ($urandom_range(0, 3) != 0) begin
				m = 2'($urandom_range(0, 3));
				cipher_pass(m, 32'd0);
				n += m[1] ? 21 : 17;
			end else begin
				logic [5:0] a;
				logic [31:0] d;
				a = 6'($urandom_range(0, 63));
				d = $urandom();
				if (a == aes_pkg::ADDR_CTRL && !expanded) d[1] = 1'b0;
				if ($urandom_range(0, 1)) read_reg(a);
				else write_reg(a, d);
				n++;
			end
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
